FILE: hw/rtl/fan_curve_hysteresis_controller_defines.svh
// Assertion macros for the fan curve controller.
`ifndef FAN_CURVE_HYSTERESIS_CONTROLLER_DEFINES_SVH
`define FAN_CURVE_HYSTERESIS_CONTROLLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// ante holds in a cycle -> cons holds in the same cycle
`define FCHC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fchc: same-cycle check failed");
// ante holds in a cycle -> cons holds in the next cycle
`define FCHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fchc: next-cycle check failed");
`else
`define FCHC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define FCHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/fchc_pkg.sv
// Shared types and constants of the fan curve controller.
`timescale 1ns / 1ps
`default_nettype none
package fchc_pkg;

  localparam int TEMP_W    = 10;
  localparam int LVL_W     = 8;
  localparam int HYST_W    = 8;
  localparam int DIVR_W    = 16;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_TEMP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_LVL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FULL_TEMP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FULL_LVL   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HYST       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_DIV   = 3'd5;

  localparam logic [TEMP_W-1:0] RST_START_TEMP = 10'd45;
  localparam logic [LVL_W-1:0]  RST_START_LVL  = 8'd35;
  localparam logic [TEMP_W-1:0] RST_FULL_TEMP  = 10'd85;
  localparam logic [LVL_W-1:0]  RST_FULL_LVL   = 8'd255;
  localparam logic [HYST_W-1:0] RST_HYST       = 8'd5;
  localparam logic [DIVR_W-1:0] RST_TEMP_DIV   = 16'd1000;

  typedef struct packed {
    logic [TEMP_W-1:0] start_temperature;
    logic [LVL_W-1:0]  start_level;
    logic [TEMP_W-1:0] full_temperature;
    logic [LVL_W-1:0]  full_level;
    logic [HYST_W-1:0] hysteresis_band;
    logic [DIVR_W-1:0] temperature_divisor;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // latch the input transaction
    logic div_start;  // launch the shared divider
    logic div_curve;  // 0: reading / divisor, 1: curve numerator / span
    logic cap_t;      // latch degrees from the divider
    logic mul_en;     // form curve numerator
    logic cap_q;      // latch curve quotient
    logic clamp_en;   // offset and clamp curve level
    logic finish;     // load result register, update applied level
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic need_curve;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fchc_ifs.sv
// Valid/ready channel interfaces for readings and results.
`timescale 1ns / 1ps
`default_nettype none
interface fchc_in_if #(parameter int READING_BITS = 20);
  logic                    valid;
  logic                    ready;
  logic [READING_BITS-1:0] reading_raw;
  logic                    reading_valid;
  logic                    write_accepted;

  modport source (output valid, output reading_raw, output reading_valid,
                  output write_accepted, input ready);
  modport sink (input valid, input reading_raw, input reading_valid,
                input write_accepted, output ready);
endinterface

interface fchc_out_if;
  logic                      valid;
  logic                      ready;
  logic [fchc_pkg::LVL_W-1:0] target_level;
  logic                      write_request;
  logic                      fan_running;

  modport source (output valid, output target_level, output write_request,
                  output fan_running, input ready);
  modport sink (input valid, input target_level, input write_request,
                input fan_running, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fchc_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
`timescale 1ns / 1ps
`default_nettype none
module fchc_div #(
  parameter int DW = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [fchc_pkg::DIVR_W-1:0]   divisor,
  input  logic [$clog2(DW+1)-1:0]       iters,
  output logic                          busy,
  output logic                          done,
  output logic [DW-1:0]                 quotient
);
  import fchc_pkg::*;

  localparam int CNT_W = $clog2(DW+1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0]     q_r, q_nxt;

  logic [DIVR_W:0]   shifted;
  logic [DIVR_W:0]   diff;
  logic              fits;

  assign shifted = {rem_r, q_r[DW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = iters;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      q_nxt    = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      q_nxt   = {q_r[DW-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fchc_dp.sv
// Datapath: scaling, curve arithmetic, level selection and result register.
`timescale 1ns / 1ps
`default_nettype none
module fchc_dp #(
  parameter int READING_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fchc_pkg::cfg_t               cfg,
  input  fchc_pkg::cmd_t               cmd,
  input  logic [READING_BITS-1:0]      reading_raw,
  input  logic                         reading_valid,
  input  logic                         write_accepted,
  output fchc_pkg::sts_t               sts,
  output logic [fchc_pkg::LVL_W-1:0]   target_level,
  output logic                         write_request,
  output logic                         fan_running
);
  import fchc_pkg::*;

  localparam int DW    = READING_BITS + LVL_W;
  localparam int CNT_W = $clog2(DW+1);
  localparam int CW    = (READING_BITS > TEMP_W ? READING_BITS : TEMP_W) + 1;
  localparam int SW    = DW + 2;

  logic [READING_BITS-1:0] raw_r;
  logic                    rvalid_r;
  logic                    acc_r;
  logic [READING_BITS-1:0] t_r;
  logic [DW-1:0]           prod_r;
  logic                    neg_r;
  logic [DW-1:0]           q_r;
  logic [LVL_W-1:0]        level_r;
  logic [LVL_W-1:0]        applied_r, applied_nxt;
  logic [LVL_W-1:0]        target_r;
  logic                    req_r;
  logic                    run_r;

  // divider hookup
  logic [DW-1:0]     div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic [CNT_W-1:0]  div_iters;
  logic [DW-1:0]     div_q;
  logic              div_busy_w;
  logic              div_done_w;
  logic [DIVR_W-1:0] div_eff;
  logic [TEMP_W-1:0] span;

  assign div_eff = (cfg.temperature_divisor == '0) ? DIVR_W'(1) : cfg.temperature_divisor;
  assign span    = cfg.full_temperature - cfg.start_temperature;

  always_comb begin
    if (cmd.div_curve) begin
      div_dividend = prod_r;
      div_divisor  = {{(DIVR_W-TEMP_W){1'b0}}, span};
      div_iters    = CNT_W'(DW);
    end else begin
      // left-aligned so READING_BITS steps leave the quotient in the low bits
      div_dividend = {raw_r, {LVL_W{1'b0}}};
      div_divisor  = div_eff;
      div_iters    = CNT_W'(READING_BITS);
    end
  end

  fchc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .busy     (div_busy_w),
    .done     (div_done_w),
    .quotient (div_q)
  );

  // threshold compares
  logic [CW-1:0] t_x, t0_x, stop_sum, dt_x;
  logic          t_zero, below_start, below_stop, bad_curve, need_curve_w;

  assign t_x         = {{(CW-READING_BITS){1'b0}}, t_r};
  assign t0_x        = {{(CW-TEMP_W){1'b0}}, cfg.start_temperature};
  assign stop_sum    = t_x + {{(CW-HYST_W){1'b0}}, cfg.hysteresis_band};
  assign dt_x        = t_x - t0_x;
  assign t_zero      = !rvalid_r || (t_r == '0);
  assign below_start = t_x < t0_x;
  assign below_stop  = stop_sum < t0_x;   // t < start - band, no sign needed
  assign bad_curve   = cfg.full_temperature <= cfg.start_temperature;

  assign need_curve_w = !t_zero && !below_start && !bad_curve;

  assign sts = '{div_busy: div_busy_w, div_done: div_done_w, need_curve: need_curve_w};

  // curve numerator |(t - t0) * (l1 - l0)|
  logic             dl_neg;
  logic [LVL_W-1:0] dl_mag;
  logic [DW-1:0]    prod_w;

  assign dl_neg = cfg.start_level > cfg.full_level;
  assign dl_mag = dl_neg ? (cfg.start_level - cfg.full_level)
                         : (cfg.full_level - cfg.start_level);
  assign prod_w = {{LVL_W{1'b0}}, dt_x[READING_BITS-1:0]} *
                  {{READING_BITS{1'b0}}, dl_mag};

  // offset by start level, truncation toward zero falls out of sign-magnitude
  logic [SW-1:0]    l0_x, l1_x, q_x, v;
  logic [LVL_W-1:0] clamp_w;

  assign l0_x = {{(SW-LVL_W){1'b0}}, cfg.start_level};
  assign l1_x = {{(SW-LVL_W){1'b0}}, cfg.full_level};
  assign q_x  = {2'b00, q_r};
  assign v    = neg_r ? (l0_x - q_x) : (l0_x + q_x);

  always_comb begin
    priority if (v[SW-1])  clamp_w = '0;
    else if (v > l1_x)     clamp_w = cfg.full_level;
    else                   clamp_w = v[LVL_W-1:0];
  end

  // level selection
  logic [LVL_W-1:0] curve_lvl, target_w;
  logic             req_w;

  assign curve_lvl = bad_curve ? cfg.full_level : level_r;

  always_comb begin
    priority if (t_zero)          target_w = '0;
    else if (applied_r != '0) begin
      priority if (below_stop)    target_w = '0;
      else if (below_start)       target_w = cfg.start_level;
      else                        target_w = curve_lvl;
    end else if (below_start)     target_w = '0;
    else                          target_w = curve_lvl;
  end

  assign req_w       = !t_zero && (target_w != applied_r);
  assign applied_nxt = (cmd.finish && req_w && acc_r) ? target_w : applied_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r <= '0;
    end else begin
      applied_r <= applied_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r    <= reading_raw;
      rvalid_r <= reading_valid;
      acc_r    <= write_accepted;
    end
    if (cmd.cap_t) begin
      t_r <= div_q[READING_BITS-1:0];
    end
    if (cmd.mul_en) begin
      prod_r <= prod_w;
      neg_r  <= dl_neg;
    end
    if (cmd.cap_q) begin
      q_r <= div_q;
    end
    if (cmd.clamp_en) begin
      level_r <= clamp_w;
    end
    if (cmd.finish) begin
      target_r <= target_w;
      req_r    <= req_w;
      run_r    <= applied_nxt != '0;
    end
  end

  assign target_level  = target_r;
  assign write_request = req_r;
  assign fan_running   = run_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fchc_ctrl.sv
// Controller: sequences one transaction through divider and, when the curve is needed, multiplier and clamp.
`timescale 1ns / 1ps
`default_nettype none
module fchc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  fchc_pkg::sts_t sts,
  output fchc_pkg::cmd_t cmd
);
  import fchc_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_D1_GO   = 4'd1;
  localparam logic [3:0] S_D1_WAIT = 4'd2;
  localparam logic [3:0] S_CHK     = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_D2_GO   = 4'd5;
  localparam logic [3:0] S_D2_WAIT = 4'd6;
  localparam logic [3:0] S_CLAMP   = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_D1_GO;
        end
      end
      S_D1_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_D1_WAIT;
      end
      S_D1_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_t = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = sts.need_curve ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_D2_GO;
      end
      S_D2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_curve = 1'b1;
        state_nxt     = S_D2_WAIT;
      end
      S_D2_WAIT: begin
        cmd.div_curve = 1'b1;
        if (sts.div_done) begin
          cmd.cap_q = 1'b1;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.finish)            out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready)  out_valid_nxt = 1'b0;
    else                                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fan_curve_hysteresis_controller.sv
// Top level: APB register file, controller and datapath of the fan curve block.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------------
//  in_chan  | in  | valid / ready    | reading_raw, reading_valid, write_accepted
//  out_chan | out | valid / ready    | target_level, write_request, fan_running
//  apb      | in  | psel/penable/... | six config registers at 4*index, pready tied 1
//
// One transaction at a time; the shared one-bit-per-cycle divider does both divisions.
// Off the curve a transaction takes one divider pass; on the curve it takes two.
// Synchronous active-low reset; config registers take their documented defaults.
// A result waits in its output register while the next transaction is taken;
// a stalled output only holds the block at its final step.
`timescale 1ns / 1ps
`default_nettype none
`include "fan_curve_hysteresis_controller_defines.svh"
module fan_curve_hysteresis_controller #(
  parameter int READING_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fchc_in_if.sink                       in_chan,
  fchc_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fchc_pkg::APB_AW-1:0]   paddr,
  input  logic [fchc_pkg::APB_DW-1:0]   pwdata,
  output logic [fchc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import fchc_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  cmd_t                 cmd;
  sts_t                 sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_TEMP: cfg_nxt.start_temperature   = pwdata[TEMP_W-1:0];
        REG_START_LVL:  cfg_nxt.start_level         = pwdata[LVL_W-1:0];
        REG_FULL_TEMP:  cfg_nxt.full_temperature    = pwdata[TEMP_W-1:0];
        REG_FULL_LVL:   cfg_nxt.full_level          = pwdata[LVL_W-1:0];
        REG_HYST:       cfg_nxt.hysteresis_band     = pwdata[HYST_W-1:0];
        REG_TEMP_DIV:   cfg_nxt.temperature_divisor = pwdata[DIVR_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_temperature   <= RST_START_TEMP;
      cfg_r.start_level         <= RST_START_LVL;
      cfg_r.full_temperature    <= RST_FULL_TEMP;
      cfg_r.full_level          <= RST_FULL_LVL;
      cfg_r.hysteresis_band     <= RST_HYST;
      cfg_r.temperature_divisor <= RST_TEMP_DIV;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_TEMP: prdata = {{(APB_DW-TEMP_W){1'b0}}, cfg_r.start_temperature};
      REG_START_LVL:  prdata = {{(APB_DW-LVL_W){1'b0}}, cfg_r.start_level};
      REG_FULL_TEMP:  prdata = {{(APB_DW-TEMP_W){1'b0}}, cfg_r.full_temperature};
      REG_FULL_LVL:   prdata = {{(APB_DW-LVL_W){1'b0}}, cfg_r.full_level};
      REG_HYST:       prdata = {{(APB_DW-HYST_W){1'b0}}, cfg_r.hysteresis_band};
      REG_TEMP_DIV:   prdata = {{(APB_DW-DIVR_W){1'b0}}, cfg_r.temperature_divisor};
      default:        prdata = '0;
    endcase
  end

  fchc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fchc_dp #(.READING_BITS(READING_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .reading_raw    (in_chan.reading_raw),
    .reading_valid  (in_chan.reading_valid),
    .write_accepted (in_chan.write_accepted),
    .sts            (sts),
    .target_level   (out_chan.target_level),
    .write_request  (out_chan.write_request),
    .fan_running    (out_chan.fan_running)
  );

  // one transaction in flight: ready drops right after an accept
  `FCHC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)
  // the shared divider is never relaunched mid-division
  `FCHC_ASSERT_SAME(a_div_no_restart, clk, rst_n, cmd.div_start, !sts.div_busy)
  // a nonzero level with no write means it already matched a running fan
  `FCHC_ASSERT_SAME(a_hold_running, clk, rst_n,
                    out_chan.valid && !out_chan.write_request && (out_chan.target_level != '0),
                    out_chan.fan_running)

endmodule
`default_nettype wire
